// ----- hw/rtl/two_axis_encoder_homing_drive_assert.svh -----
// Assertion macros shared by the checker file of the homing drive.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef TWO_AXIS_ENCODER_HOMING_DRIVE_ASSERT_SVH
`define TWO_AXIS_ENCODER_HOMING_DRIVE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define TAEHD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define TAEHD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/taehd_pkg.sv -----
// Package for the two-axis encoder homing drive: field widths, bus layout,
// register indexes, reset values and direction codes. No dependencies.
`default_nettype none

package taehd_pkg;

  // Parameter defaults
  localparam int unsigned POS_BITS_DEF  = 32;
  localparam int unsigned DUTY_BITS_DEF = 14;

  // Field widths
  localparam int unsigned COUNT_W     = 16;
  localparam int unsigned DRIVE_W     = 16;
  localparam int unsigned DUTY_FIELD_W = 14;
  localparam int unsigned DIR_W       = 2;
  localparam int unsigned POS_FIELD_W = 32;
  localparam int unsigned RUN_W       = 8;
  localparam int unsigned TOL_W       = 16;

  // Configuration port
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_PWM_PERIOD      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HOME_DUTY       = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_STABLE_REQUIRED = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_STILL_TOLERANCE = 2'd3;

  localparam logic [DUTY_FIELD_W-1:0] PWM_PERIOD_RST      = 14'd1000;
  localparam logic [DUTY_FIELD_W-1:0] HOME_DUTY_RST       = 14'd200;
  localparam logic [RUN_W-1:0]        STABLE_REQUIRED_RST = 8'd5;
  localparam logic [TOL_W-1:0]        STILL_TOLERANCE_RST = 16'd0;

  localparam logic [COUNT_W-1:0] LAST_COUNT_RST = 16'hFFFF;

  // Direction codes (yaw and pitch motors are wired with opposite sense)
  localparam logic [DIR_W-1:0] DIR_YAW_REV   = 2'd1;
  localparam logic [DIR_W-1:0] DIR_YAW_FWD   = 2'd2;
  localparam logic [DIR_W-1:0] DIR_PITCH_FWD = 2'd1;
  localparam logic [DIR_W-1:0] DIR_PITCH_REV = 2'd2;

  // Input bus layout
  localparam int unsigned IN_TDATA_W = 64;
  localparam int unsigned IN_TUSER_W = 1;

  // Output bus layout
  localparam int unsigned OUT_DUTY_YAW_LSB   = 0;
  localparam int unsigned OUT_DIR_YAW_LSB    = 14;
  localparam int unsigned OUT_DUTY_PITCH_LSB = 16;
  localparam int unsigned OUT_DIR_PITCH_LSB  = 30;
  localparam int unsigned OUT_YPOS_LSB       = 32;
  localparam int unsigned OUT_PPOS_LSB       = 64;
  localparam int unsigned OUT_HOMING_BIT     = 96;
  localparam int unsigned OUT_DONE_BIT       = 97;
  localparam int unsigned OUT_USED_W         = 98;
  localparam int unsigned OUT_TDATA_W        = 104;

endpackage

`default_nettype wire

// ----- hw/rtl/two_axis_encoder_homing_drive.sv -----
// Two-axis encoder homing drive: encoder unwrap, hard-stop homing sequencer
// and Q15-to-duty conversion in one pipelined module. Depends on taehd_pkg.
`default_nettype none

// One input transaction is one control sample: two raw wrapping 16-bit
// encoder counts, a start-homing flag and two signed Q15 drive requests. One
// result transaction leaves for every sample, in order. The block takes a
// new sample every clock cycle unless the output stalls. A sample passes
// a two-register pipeline (input register, then result register), and the
// position accumulators and homing counter advance as it enters the result
// register. in_tready drops only while both registers are full and
// out_tready is low. Each count is unwrapped by the signed modulo 65536
// step from the previous count into a POSITION_BITS-wide position
// (after reset the previous count is 0xFFFF and positions are 0). A sample
// with start_home set begins homing: both axes are driven in reverse at
// home_duty. Once both axes move no more than still_tolerance counts per
// sample for stable_required samples in a row, the result shows duty 0,
// both positions 0, homing_active 0 and home_done 1. Outside homing,
// duty = floor(|drive| * pwm_period / 2^15), saturated to 2^DUTY_BITS - 1.
// Write configuration only while no transaction is in flight.
module two_axis_encoder_homing_drive
  import taehd_pkg::*;
#(
  parameter int unsigned POSITION_BITS = POS_BITS_DEF,  // 17..64
  parameter int unsigned DUTY_BITS     = DUTY_BITS_DEF  // 8..16
) (
  input  wire                        clk,
  input  wire                        rst_n,
  // Configuration write port
  input  wire                        cfg_we,
  input  wire  [CFG_INDEX_W-1:0]     cfg_index,
  input  wire  [CFG_DATA_W-1:0]      cfg_data,
  // Sample input
  input  wire                        in_tvalid,
  output logic                       in_tready,
  // [15:0] yaw_enc, [31:16] pitch_enc, [47:32] drive_yaw, [63:48] drive_pitch
  input  wire  [IN_TDATA_W-1:0]      in_tdata,
  // [0] start_home
  input  wire  [IN_TUSER_W-1:0]      in_tuser,
  // Result output
  output logic                       out_tvalid,
  input  wire                        out_tready,
  // [13:0] yaw_duty, [15:14] yaw_dir, [29:16] pitch_duty, [31:30] pitch_dir,
  // [63:32] yaw_position, [95:64] pitch_position, [96] homing_active,
  // [97] home_done, [103:98] zero
  output logic [OUT_TDATA_W-1:0]     out_tdata
);

  localparam int unsigned EXT_W = (POSITION_BITS > POS_FIELD_W) ? POSITION_BITS : POS_FIELD_W;
  localparam int unsigned MAG_W = COUNT_W + 1;
  localparam int unsigned PROD_W = MAG_W + DUTY_FIELD_W;
  localparam logic [MAG_W-1:0] DUTY_MAX = MAG_W'((1 << DUTY_BITS) - 1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [DUTY_FIELD_W-1:0] pwm_period_r;
  logic [DUTY_FIELD_W-1:0] home_duty_r;
  logic [RUN_W-1:0]        stable_req_r;
  logic [TOL_W-1:0]        still_tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_period_r <= PWM_PERIOD_RST;
      home_duty_r  <= HOME_DUTY_RST;
      stable_req_r <= STABLE_REQUIRED_RST;
      still_tol_r  <= STILL_TOLERANCE_RST;
    end else if (cfg_we) begin
      // mask each write to the register's width
      unique case (cfg_index)
        REG_PWM_PERIOD:      pwm_period_r <= cfg_data[DUTY_FIELD_W-1:0];
        REG_HOME_DUTY:       home_duty_r  <= cfg_data[DUTY_FIELD_W-1:0];
        REG_STABLE_REQUIRED: stable_req_r <= cfg_data[RUN_W-1:0];
        REG_STILL_TOLERANCE: still_tol_r  <= cfg_data[TOL_W-1:0];
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control
  // ---------------------------------------------------------------------------
  logic s1_valid_r;
  logic out_valid_r;
  logic out_free;
  logic s1_adv;

  // The result register can take a new transaction when empty or draining.
  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input register: hold the sample fields
  // ---------------------------------------------------------------------------
  logic [COUNT_W-1:0]        s1_ycnt_r;
  logic [COUNT_W-1:0]        s1_pcnt_r;
  logic                      s1_start_r;
  logic signed [DRIVE_W-1:0] s1_dy_r;
  logic signed [DRIVE_W-1:0] s1_dp_r;

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_ycnt_r  <= in_tdata[15:0];
      s1_pcnt_r  <= in_tdata[31:16];
      s1_dy_r    <= in_tdata[47:32];
      s1_dp_r    <= in_tdata[63:48];
      s1_start_r <= in_tuser[0];
    end
  end

  // ---------------------------------------------------------------------------
  // Sample state: previous counts, positions, homing sequencer
  // ---------------------------------------------------------------------------
  logic [COUNT_W-1:0]       last_yaw_r;
  logic [COUNT_W-1:0]       last_pitch_r;
  logic [POSITION_BITS-1:0] yaw_acc_r;
  logic [POSITION_BITS-1:0] pitch_acc_r;
  logic                     homing_r;
  logic [RUN_W-1:0]         still_run_r;

  logic [POSITION_BITS-1:0] yaw_acc_nxt;
  logic [POSITION_BITS-1:0] pitch_acc_nxt;
  logic                     homing_nxt;
  logic [RUN_W-1:0]         still_run_nxt;

  // Unwrap: the 16-bit difference read as signed is the step.
  logic [COUNT_W-1:0] ystep;
  logic [COUNT_W-1:0] pstep;
  logic [MAG_W-1:0]   ymag;
  logic [MAG_W-1:0]   pmag;
  logic               both_still;
  logic [RUN_W-1:0]   run_inc;
  logic               done;

  assign ystep = s1_ycnt_r - last_yaw_r;
  assign pstep = s1_pcnt_r - last_pitch_r;
  assign ymag  = ystep[COUNT_W-1] ? (MAG_W'(1) << COUNT_W) - {1'b0, ystep} : {1'b0, ystep};
  assign pmag  = pstep[COUNT_W-1] ? (MAG_W'(1) << COUNT_W) - {1'b0, pstep} : {1'b0, pstep};

  assign both_still = (ymag <= {1'b0, still_tol_r}) && (pmag <= {1'b0, still_tol_r});

  // Count still samples, saturating; any movement restarts the run.
  assign run_inc = !both_still ? '0 :
                   (still_run_r == {RUN_W{1'b1}}) ? still_run_r : still_run_r + 1'b1;

  // A start sample only sets the baseline and is never judged.
  assign done = !s1_start_r && homing_r && (run_inc >= stable_req_r);

  always_comb begin
    logic [POSITION_BITS-1:0] ysum;
    logic [POSITION_BITS-1:0] psum;
    ysum = yaw_acc_r + {{(POSITION_BITS-COUNT_W){ystep[COUNT_W-1]}}, ystep};
    psum = pitch_acc_r + {{(POSITION_BITS-COUNT_W){pstep[COUNT_W-1]}}, pstep};

    yaw_acc_nxt   = done ? '0 : ysum;
    pitch_acc_nxt = done ? '0 : psum;

    if (s1_start_r) begin
      homing_nxt    = 1'b1;
      still_run_nxt = '0;
    end else if (homing_r) begin
      homing_nxt    = !done;
      still_run_nxt = done ? '0 : run_inc;
    end else begin
      homing_nxt    = 1'b0;
      still_run_nxt = still_run_r;
    end
  end

  // Advance the state only when the sample moves into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_yaw_r   <= LAST_COUNT_RST;
      last_pitch_r <= LAST_COUNT_RST;
      yaw_acc_r    <= '0;
      pitch_acc_r  <= '0;
      homing_r     <= 1'b0;
      still_run_r  <= '0;
    end else if (s1_adv) begin
      last_yaw_r   <= s1_ycnt_r;
      last_pitch_r <= s1_pcnt_r;
      yaw_acc_r    <= yaw_acc_nxt;
      pitch_acc_r  <= pitch_acc_nxt;
      homing_r     <= homing_nxt;
      still_run_r  <= still_run_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Drive conversion: |Q15| * period >> 15, saturated
  // ---------------------------------------------------------------------------
  logic [MAG_W-1:0]        dmag_y;
  logic [MAG_W-1:0]        dmag_p;
  logic [PROD_W-1:0]       prod_y;
  logic [PROD_W-1:0]       prod_p;
  logic [MAG_W-1:0]        dfull_y;
  logic [MAG_W-1:0]        dfull_p;
  logic [DUTY_BITS-1:0]    dsat_y;
  logic [DUTY_BITS-1:0]    dsat_p;
  logic [DUTY_BITS-1:0]    hsat;

  assign dmag_y = s1_dy_r[DRIVE_W-1] ? (MAG_W'(1) << DRIVE_W) - {1'b0, s1_dy_r}
                                     : {1'b0, s1_dy_r};
  assign dmag_p = s1_dp_r[DRIVE_W-1] ? (MAG_W'(1) << DRIVE_W) - {1'b0, s1_dp_r}
                                     : {1'b0, s1_dp_r};

  assign prod_y = PROD_W'(dmag_y) * PROD_W'(pwm_period_r);
  assign prod_p = PROD_W'(dmag_p) * PROD_W'(pwm_period_r);

  assign dfull_y = MAG_W'(prod_y >> 15);
  assign dfull_p = MAG_W'(prod_p >> 15);

  assign dsat_y = (dfull_y > DUTY_MAX) ? DUTY_BITS'(DUTY_MAX) : DUTY_BITS'(dfull_y);
  assign dsat_p = (dfull_p > DUTY_MAX) ? DUTY_BITS'(DUTY_MAX) : DUTY_BITS'(dfull_p);
  assign hsat   = (MAG_W'(home_duty_r) > DUTY_MAX) ? DUTY_BITS'(DUTY_MAX)
                                                   : DUTY_BITS'(home_duty_r);

  // ---------------------------------------------------------------------------
  // Result selection
  // ---------------------------------------------------------------------------
  logic [DUTY_FIELD_W-1:0] yaw_duty;
  logic [DUTY_FIELD_W-1:0] pitch_duty;
  logic [DIR_W-1:0]        yaw_dir;
  logic [DIR_W-1:0]        pitch_dir;
  logic signed [EXT_W-1:0] ypos_ext;
  logic signed [EXT_W-1:0] ppos_ext;

  always_comb begin
    if (homing_nxt) begin
      // reverse both axes into the hard stops
      yaw_duty   = DUTY_FIELD_W'(hsat);
      pitch_duty = DUTY_FIELD_W'(hsat);
      yaw_dir    = DIR_YAW_REV;
      pitch_dir  = DIR_PITCH_REV;
    end else if (done) begin
      yaw_duty   = '0;
      pitch_duty = '0;
      yaw_dir    = DIR_YAW_FWD;
      pitch_dir  = DIR_PITCH_FWD;
    end else begin
      yaw_duty   = DUTY_FIELD_W'(dsat_y);
      pitch_duty = DUTY_FIELD_W'(dsat_p);
      yaw_dir    = s1_dy_r[DRIVE_W-1] ? DIR_YAW_REV : DIR_YAW_FWD;
      pitch_dir  = s1_dp_r[DRIVE_W-1] ? DIR_PITCH_REV : DIR_PITCH_FWD;
    end
  end

  // Sign-extend narrow accumulators, drop the top of wide ones.
  assign ypos_ext = EXT_W'($signed(yaw_acc_nxt));
  assign ppos_ext = EXT_W'($signed(pitch_acc_nxt));

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_tdata_r <= {(OUT_TDATA_W-OUT_USED_W)'(0), done, homing_nxt,
                      ppos_ext[POS_FIELD_W-1:0], ypos_ext[POS_FIELD_W-1:0],
                      pitch_dir, pitch_duty, yaw_dir, yaw_duty};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

endmodule

`default_nettype wire

// ----- hw/rtl/taehd_checker.sv -----
// Port-level checker for the two-axis encoder homing drive, bound to the top level.
// Depends on taehd_pkg and two_axis_encoder_homing_drive_assert.svh.
`default_nettype none

`include "two_axis_encoder_homing_drive_assert.svh"

module taehd_checker
  import taehd_pkg::*;
(
  input wire                     clk,
  input wire                     rst_n,
  input wire                     out_tvalid,
  input wire                     out_tready,
  input wire [OUT_TDATA_W-1:0]   out_tdata
);

  logic [DIR_W-1:0] yaw_dir;
  logic [DIR_W-1:0] pitch_dir;
  logic             homing;
  logic             done;
  logic             stalled;
  logic             done_clean;
  logic             homing_rev;
  logic             dirs_legal;

  assign yaw_dir   = out_tdata[OUT_DIR_YAW_LSB +: DIR_W];
  assign pitch_dir = out_tdata[OUT_DIR_PITCH_LSB +: DIR_W];
  assign homing    = out_tdata[OUT_HOMING_BIT];
  assign done      = out_tdata[OUT_DONE_BIT];
  assign stalled   = out_tvalid && !out_tready;

  assign done_clean = (out_tdata[OUT_YPOS_LSB +: POS_FIELD_W] == '0) &&
                      (out_tdata[OUT_PPOS_LSB +: POS_FIELD_W] == '0) &&
                      (out_tdata[OUT_DUTY_YAW_LSB +: DUTY_FIELD_W] == '0) &&
                      (out_tdata[OUT_DUTY_PITCH_LSB +: DUTY_FIELD_W] == '0) && !homing;

  assign homing_rev = (yaw_dir == DIR_YAW_REV) && (pitch_dir == DIR_PITCH_REV) && !done;

  assign dirs_legal = ((yaw_dir == DIR_YAW_REV) || (yaw_dir == DIR_YAW_FWD)) &&
                      ((pitch_dir == DIR_PITCH_REV) || (pitch_dir == DIR_PITCH_FWD));

  // Hold a stalled result transaction.
  `TAEHD_ASSERT_NEXT(a_out_hold, stalled, out_tvalid && $stable(out_tdata), "result not held")

  // Completion zeroes both positions and stops the drive.
  `TAEHD_ASSERT_NOW(a_done_zero, out_tvalid && done, done_clean, "home_done result not zeroed")

  // While homing both axes run in reverse.
  `TAEHD_ASSERT_NOW(a_homing_rev, out_tvalid && homing, homing_rev, "homing not in reverse")

  // Direction codes of a valid result are always one of the two legal codes.
  `TAEHD_ASSERT_NOW(a_dir_legal, out_tvalid, dirs_legal, "illegal direction code")

endmodule

bind two_axis_encoder_homing_drive taehd_checker u_taehd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
